// File: rtl/sql_bind_variable_stripper_top_defines.svh
//------------------------------------------------------------------------------
// sql_bind_variable_stripper_top_defines
// assertion macros used by the rewriter serializer (sbvs_back)
//------------------------------------------------------------------------------
`ifndef SQL_BIND_VARIABLE_STRIPPER_TOP_DEFINES_SVH
`define SQL_BIND_VARIABLE_STRIPPER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define SBVS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define SBVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sbvs_pkg.sv
//------------------------------------------------------------------------------
// sbvs_pkg
// types and constants of the sql bind variable rewriter
//------------------------------------------------------------------------------
package sbvs_pkg;

	// characters the scanner looks for or writes
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// configuration port
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [0:0]  REG_STRIP_MODE = 1'b0;

	// queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// most result items one input item can cause
	localparam int unsigned MAX_RES = 3;

	typedef enum logic [2:0] {
		ST_NORMAL = 3'd0,
		ST_QUOTE  = 3'd1,
		ST_NAME   = 3'd2,
		ST_TAG    = 3'd3,
		ST_COLON  = 3'd4
	} scan_state_t;

	// all results of one input item
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] chars;    // chars[0] goes out first
		logic [1:0]              cnt;      // number of results, 1..3 in the queue
		logic                    has_char; // 0 for a bare end marker
		logic                    text_end; // statement ends with this item
	} bundle_t;

endpackage

// File: rtl/sbvs_front.sv
//------------------------------------------------------------------------------
// sbvs_front
// scanner: tracks quotes and binds, turns each input byte that has results into a bundle
//------------------------------------------------------------------------------
module sbvs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              strip_mode,
	input  logic              in_valid,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	input  logic              q_full,
	output logic              in_ready,
	output logic              push,
	output sbvs_pkg::bundle_t push_item
);

	sbvs_pkg::scan_state_t scan_q, scan_raw, scan_d;
	logic                  dbl_q, dbl_d;
	logic                  accept;
	logic                  alnum, is_quote, plain_in;
	logic [7:0]            close_ch;
	sbvs_pkg::bundle_t     b;

	function automatic logic is_alnum(input logic [7:0] c);
		logic r;
		r = 1'b0;
		if (c >= 8'h30 && c <= 8'h39) r = 1'b1;
		if (c >= 8'h41 && c <= 8'h5A) r = 1'b1;
		if (c >= 8'h61 && c <= 8'h7A) r = 1'b1;
		if (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7) r = 1'b1;
		return r;
	endfunction

	function automatic sbvs_pkg::bundle_t push_ch(input sbvs_pkg::bundle_t bi,
			input logic [7:0] x);
		sbvs_pkg::bundle_t bo;
		bo = bi;
		if (bo.cnt != 2'd3) begin
			bo.chars[bo.cnt] = x;
			bo.cnt = bo.cnt + 2'd1;
		end
		return bo;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign alnum    = is_alnum(in_char);
	assign is_quote = (in_char == sbvs_pkg::CH_SQ) || (in_char == sbvs_pkg::CH_DQ);
	assign close_ch = dbl_q ? sbvs_pkg::CH_DQ : sbvs_pkg::CH_SQ;

	// byte falls through to plain text handling
	always_comb begin
		unique case (scan_q)
			sbvs_pkg::ST_QUOTE, sbvs_pkg::ST_TAG: plain_in = 1'b0;
			sbvs_pkg::ST_COLON: plain_in = (in_char != sbvs_pkg::CH_COLON) && !alnum &&
					(in_char != sbvs_pkg::CH_LT);
			sbvs_pkg::ST_NAME: plain_in = !alnum && (in_char != sbvs_pkg::CH_LT);
			default: plain_in = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		scan_raw = scan_q;
		dbl_d    = dbl_q;
		unique case (scan_q)
			sbvs_pkg::ST_QUOTE: begin
				if (in_char == close_ch) scan_raw = sbvs_pkg::ST_NORMAL;
			end
			sbvs_pkg::ST_COLON: begin
				if (in_char == sbvs_pkg::CH_COLON) scan_raw = sbvs_pkg::ST_NORMAL;
				else if (alnum) scan_raw = sbvs_pkg::ST_NAME;
				else if (in_char == sbvs_pkg::CH_LT) scan_raw = sbvs_pkg::ST_TAG;
			end
			sbvs_pkg::ST_NAME: begin
				if (in_char == sbvs_pkg::CH_LT) scan_raw = sbvs_pkg::ST_TAG;
			end
			sbvs_pkg::ST_TAG: begin
				if (in_char == sbvs_pkg::CH_GT) scan_raw = sbvs_pkg::ST_NORMAL;
			end
			default: scan_raw = sbvs_pkg::ST_NORMAL;
		endcase
		if (plain_in) begin
			if (is_quote) begin
				scan_raw = sbvs_pkg::ST_QUOTE;
				dbl_d    = (in_char == sbvs_pkg::CH_DQ);
			end else if (in_char == sbvs_pkg::CH_COLON) begin
				scan_raw = strip_mode ? sbvs_pkg::ST_COLON : sbvs_pkg::ST_NAME;
			end else begin
				scan_raw = sbvs_pkg::ST_NORMAL;
			end
		end
		scan_d = scan_raw;
		if (in_last) begin
			scan_d = sbvs_pkg::ST_NORMAL;
			dbl_d  = 1'b0;
		end
	end

	// results of this byte
	always_comb begin
		b = '0;
		b.has_char = 1'b1;
		unique case (scan_q)
			sbvs_pkg::ST_QUOTE: b = push_ch(b, in_char);
			sbvs_pkg::ST_COLON: begin
				if (in_char == sbvs_pkg::CH_COLON) begin
					b = push_ch(b, sbvs_pkg::CH_COLON);
					b = push_ch(b, sbvs_pkg::CH_COLON);
				end else begin
					b = push_ch(b, sbvs_pkg::CH_SQ);
					b = push_ch(b, sbvs_pkg::CH_SQ);
				end
			end
			sbvs_pkg::ST_NAME: begin
				if (alnum && !strip_mode) b = push_ch(b, in_char);
				if (in_char == sbvs_pkg::CH_LT && !strip_mode) b = push_ch(b, sbvs_pkg::CH_SPACE);
			end
			sbvs_pkg::ST_TAG: begin
				if (!strip_mode) b = push_ch(b, sbvs_pkg::CH_SPACE);
			end
			default: ;
		endcase
		// a plain text colon in strip mode is held, every other plain text byte passes
		if (plain_in && !(in_char == sbvs_pkg::CH_COLON && strip_mode)) b = push_ch(b, in_char);
		if (in_last) begin
			if (scan_raw == sbvs_pkg::ST_COLON) begin
				b = push_ch(b, sbvs_pkg::CH_SQ);
				b = push_ch(b, sbvs_pkg::CH_SQ);
			end
			if (b.cnt == 2'd0) begin
				b.cnt      = 2'd1;
				b.has_char = 1'b0;
			end
			b.text_end = 1'b1;
		end
	end

	assign push      = accept && (b.cnt != 2'd0);
	assign push_item = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= sbvs_pkg::ST_NORMAL;
			dbl_q  <= 1'b0;
		end else if (accept) begin
			scan_q <= scan_d;
			dbl_q  <= dbl_d;
		end
	end

endmodule

// File: rtl/sbvs_queue.sv
//------------------------------------------------------------------------------
// sbvs_queue
// short fifo of bundles between scanner and serializer
//------------------------------------------------------------------------------
module sbvs_queue #(
	parameter int unsigned QDEPTH = sbvs_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sbvs_pkg::bundle_t push_item,
	input  logic              pop,
	output logic              full,
	output logic              q_valid,
	output sbvs_pkg::bundle_t q_item
);

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	sbvs_pkg::bundle_t mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full    = (count_q == CNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// File: rtl/sbvs_back.sv
//------------------------------------------------------------------------------
// sbvs_back
// serializer: unless m_tready stalls, hands out a bundle one result item per cycle
//------------------------------------------------------------------------------
`include "sql_bind_variable_stripper_top_defines.svh"

module sbvs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  sbvs_pkg::bundle_t q_item,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	logic       m_tvalid_q;
	logic [7:0] data_q;
	logic       char_valid_q, run_last_q, text_end_q;
	logic [1:0] idx_q;
	logic       load, cur_last;

	assign cur_last = (idx_q == q_item.cnt - 2'd1);
	assign load     = q_valid && (!m_tvalid_q || m_tready);
	assign pop      = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
				idx_q      <= cur_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q       <= q_item.has_char ? q_item.chars[idx_q] : 8'h00;
			char_valid_q <= q_item.has_char;
			run_last_q   <= cur_last;
			text_end_q   <= cur_last && q_item.text_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = {run_last_q, char_valid_q};
	assign m_tlast  = text_end_q;

	`SBVS_ASSERT_NOW(a_end_is_run_last, m_tvalid_q && text_end_q, run_last_q,
		"text end without run last")
	`SBVS_ASSERT_NOW(a_bare_marker, m_tvalid_q && !char_valid_q,
		run_last_q && text_end_q && (data_q == 8'h00), "bare marker malformed")
	`SBVS_ASSERT_NOW(a_idx_in_range, q_valid, (q_item.cnt != 2'd0) && (idx_q < q_item.cnt),
		"serializer index outside bundle")
	`SBVS_ASSERT_NEXT(a_load_shows, load, m_tvalid_q, "loaded item not shown")

endmodule

// File: rtl/sql_bind_variable_stripper_top.sv
//------------------------------------------------------------------------------
// sql_bind_variable_stripper_top
// rewrites bind variables :name<type> in a byte stream of sql text
//------------------------------------------------------------------------------
// channel  | dir | handshake            | payload
// s_*      | in  | s_tvalid / s_tready  | tdata = in_char, tlast = text_last
// m_*      | out | m_tvalid / m_tready  | tdata = out_char, tuser = {run_last,
//          |     |                      | char_valid}, tlast = text_end
// apb      | in  | psel & penable       | reg 0 at byte 0: strip_mode
//
// one input item is taken per cycle while the bundle queue has room; the
// scanner state loop updates in the cycle of acceptance
// the serializer sends one result item per cycle while m_tready allows, so
// an item causing k results holds the back end until all k are sent (k is 1..3)
// the first result of an input item passes the bundle queue, then the output register
// reset clears scanner state, queue pointers and output valid; strip_mode 0
// output stalls fill the queue and then drop s_tready, nothing is lost
//------------------------------------------------------------------------------
module sql_bind_variable_stripper_top #(
	parameter int unsigned QDEPTH = sbvs_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] in_char
	input  logic                            s_tlast,   // text_last
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] out_char
	output logic [1:0]                      m_tuser,   // [0] char_valid, [1] run_last
	output logic                            m_tlast,   // text_end
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sbvs_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	logic              strip_mode_q;
	logic              cfg_wr;
	logic              q_full, q_valid, push, pop;
	sbvs_pkg::bundle_t push_item, q_item;

	// apb register file: a single mode bit at word 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
			(paddr[2] == sbvs_pkg::REG_STRIP_MODE);
	assign prdata = (paddr[2] == sbvs_pkg::REG_STRIP_MODE) ? {31'd0, strip_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_mode_q <= 1'b0;
		end else if (cfg_wr) begin
			strip_mode_q <= pwdata[0];
		end
	end

	// front: classify each byte and build its result bundle
	sbvs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.strip_mode (strip_mode_q),
		.in_valid   (s_tvalid),
		.in_char    (s_tdata),
		.in_last    (s_tlast),
		.q_full     (q_full),
		.in_ready   (s_tready),
		.push       (push),
		.push_item  (push_item)
	);

	// decouples scanner from output stalls
	sbvs_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// back: one result item per cycle into the output register, unless m_tready stalls it
	sbvs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
